/* src/indexed_list_engine_top_macros.svh */
// assertion macros for the indexed list engine
`ifndef INDEXED_LIST_ENGINE_TOP_MACROS_SVH
`define INDEXED_LIST_ENGINE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define ILE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define ILE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/ile_pkg.sv */
// shared types and constants of the indexed list engine
package ile_pkg;

  localparam int DATA_W    = 16;
  localparam int VAL_W     = 21;
  localparam int MODE_W    = 3;
  localparam int POS_W     = 6;
  localparam int STATUS_W  = 2;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 24;

  localparam logic [MODE_W-1:0] MODE_LIST   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SUM    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MIN    = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IDX_ERR = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  localparam logic signed [DATA_W-1:0] MIN_START = 16'sd10001;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_PUT,
    S_DEL,
    S_SCAN,
    S_FIN,
    S_RESP
  } ile_state_t;

  typedef struct packed {
    logic                       valid;
    logic [STATUS_W-1:0]        status;
    logic signed [VAL_W-1:0]    value;
    logic                       last;
  } ile_beat_t;

endpackage

/* src/ile_mem.sv */
// entry store: one write port, one registered read port with enable
module ile_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/ile_out.sv */
// output register stage of the result stream
module ile_out (
  input  logic                          clk,
  input  logic                          rst,
  input  ile_pkg::ile_beat_t            load,
  input  logic                          ready,
  output logic                          valid,
  output logic                          free,
  output logic [ile_pkg::STATUS_W-1:0]  status,
  output logic signed [ile_pkg::VAL_W-1:0] value,
  output logic                          last
);
  import ile_pkg::*;

  assign free = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load.valid) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid) begin
      status <= load.status;
      value  <= load.value;
      last   <= load.last;
    end
  end

endmodule

/* src/indexed_list_engine_top.sv */
// top level of the indexed list engine: sequencer around the entry store
//
//  channel | dir | fields (lowest bit up)                         | accepted when
//  s_*     | in  | tdata: mode[2:0] position[8:3] item_value[24:9] | s_tvalid && s_tready
//  m_*     | out | tdata: result_value[20:0]; tuser: status; tlast | m_tvalid && m_tready
//
// one item at a time; s_tready is high only while the sequencer is idle
// list: walks the n entries; sum and minimum: walk them, then finish and respond
// insert at p: a shift walk from the end down to p, one write, then a listing of n + 1 entries
// delete at p: a walk from p to the end; errors, empty cases and append skip the shift walk
// the walk runs one entry per cycle, save for m_tready stalls, through the single read port of the store
// reset clears the state, the fill count and the read flag; stalls on m_tready pause the listing walk
`include "indexed_list_engine_top_macros.svh"

module indexed_list_engine_top #(
  parameter int CAPACITY = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // mode[2:0], position[8:3], item_value[24:9], zero fill above
  input  logic [ile_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // result_value[20:0], zero fill above
  output logic [ile_pkg::M_TDATA_W-1:0]   m_tdata,
  // status[1:0]
  output logic [ile_pkg::STATUS_W-1:0]    m_tuser,
  output logic                            m_tlast
);
  import ile_pkg::*;

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W  = (CW > POS_W) ? CW : POS_W;
  localparam int ACC_W  = (DATA_W + CW > VAL_W + 1) ? DATA_W + CW : VAL_W + 1;

  // sequencer state and walk registers
  ile_state_t               state, state_next;
  logic [CW-1:0]            count;
  logic [CW-1:0]            ptr;
  logic [CW-1:0]            left;
  logic [CW-1:0]            pos_r;
  logic [MODE_W-1:0]        op;
  logic [DATA_W-1:0]        val_r;
  logic signed [ACC_W-1:0]  acc;
  logic                     rd_valid;
  logic                     rd_last;
  logic [AW-1:0]            rd_addr_q;
  logic                     first;
  logic [STATUS_W-1:0]      resp_status;
  logic signed [VAL_W-1:0]  resp_value;
  logic                     listing;

  // input beat fields
  logic [MODE_W-1:0]        in_mode;
  logic [POS_W-1:0]         in_pos;
  logic [DATA_W-1:0]        in_val;
  logic                     accept;
  logic [CMP_W-1:0]         pos_ext;
  logic [CMP_W-1:0]         cnt_ext;
  logic                     full;

  assign in_mode = s_tdata[MODE_W-1:0];
  assign in_pos  = s_tdata[MODE_W+POS_W-1:MODE_W];
  assign in_val  = s_tdata[MODE_W+POS_W+DATA_W-1:MODE_W+POS_W];
  assign accept  = s_tvalid && s_tready;
  assign pos_ext = CMP_W'(in_pos);
  assign cnt_ext = CMP_W'(count);
  assign full    = (count == CW'(CAPACITY));

  // list, append and insert use the listing walk, except when they end in a single status response
  assign listing = op inside {MODE_LIST, MODE_APPEND, MODE_INSERT};

  // store ports
  logic                     rd_en;
  logic [AW-1:0]            raddr;
  logic signed [DATA_W-1:0] rd_data;
  logic                     mem_we;
  logic [AW-1:0]            waddr;
  logic [DATA_W-1:0]        wdata;

  // read data consumed this cycle, beat toward the output stage
  logic                     consume;
  ile_beat_t                load;
  logic                     out_free;
  logic signed [VAL_W-1:0]  out_value;

  logic signed [ACC_W-1:0]  rd_ext;
  logic [ACC_W-VAL_W:0]     acc_hi;
  logic signed [VAL_W-1:0]  sum_sat;

  assign rd_ext = ACC_W'(rd_data);
  assign raddr  = ptr[AW-1:0];

  // saturate the running sum to the result range
  assign acc_hi = acc[ACC_W-1:VAL_W-1];
  always_comb begin
    if ((&acc_hi) || !(|acc_hi)) begin
      sum_sat = acc[VAL_W-1:0];
    end else if (acc[ACC_W-1]) begin
      sum_sat = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  ile_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (DATA_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rd_data)
  );

  ile_out u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .ready  (m_tready),
    .valid  (m_tvalid),
    .free   (out_free),
    .status (m_tuser),
    .value  (out_value),
    .last   (m_tlast)
  );

  assign m_tdata  = {{(M_TDATA_W-VAL_W){1'b0}}, out_value};
  // no beat is taken while reset is held
  assign s_tready = (state == S_IDLE) && !rst;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_LIST, MODE_SUM, MODE_MIN: begin
              state_next = (count == '0) ? S_RESP : S_SCAN;
            end
            MODE_APPEND: begin
              state_next = full ? S_RESP : S_PUT;
            end
            MODE_INSERT: begin
              if (pos_ext > cnt_ext || full) begin
                state_next = S_RESP;
              end else if (pos_ext == cnt_ext) begin
                state_next = S_PUT;
              end else begin
                state_next = S_SHIFT_UP;
              end
            end
            MODE_DELETE: begin
              state_next = (pos_ext >= cnt_ext) ? S_RESP : S_DEL;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SHIFT_UP: begin
        if (left == '0) begin
          state_next = S_PUT;
        end
      end
      S_PUT:  state_next = S_SCAN;
      S_DEL: begin
        if (left == '0) begin
          state_next = S_RESP;
        end
      end
      S_SCAN: begin
        if (consume && rd_last) begin
          state_next = listing ? S_IDLE : S_FIN;
        end
      end
      S_FIN:  state_next = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // store and output stage controls
  always_comb begin
    consume = 1'b0;
    rd_en   = 1'b0;
    mem_we  = 1'b0;
    waddr   = '0;
    wdata   = '0;
    load    = '0;
    case (state)
      S_SHIFT_UP: begin
        // entry read last cycle moves one place toward the end
        consume = rd_valid;
        rd_en   = (left != '0);
        mem_we  = rd_valid;
        waddr   = rd_addr_q + 1'b1;
        wdata   = rd_data;
      end
      S_PUT: begin
        mem_we = 1'b1;
        waddr  = pos_r[AW-1:0];
        wdata  = val_r;
      end
      S_DEL: begin
        // first read is the removed entry, the rest move one place forward
        consume = rd_valid;
        rd_en   = (left != '0);
        mem_we  = rd_valid && !first;
        waddr   = rd_addr_q - 1'b1;
        wdata   = rd_data;
      end
      S_SCAN: begin
        if (listing) begin
          consume      = rd_valid && out_free;
          load.valid   = consume;
          load.status  = ST_OK;
          load.value   = VAL_W'(rd_data);
          load.last    = rd_last;
        end else begin
          consume = rd_valid;
        end
        rd_en = (left != '0) && (!rd_valid || consume);
      end
      S_RESP: begin
        load.valid  = out_free;
        load.status = resp_status;
        load.value  = resp_value;
        load.last   = 1'b1;
      end
      default: begin
        consume = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= rd_en || (rd_valid && !consume);
      if (state == S_PUT) begin
        count <= count + 1'b1;
      end else if (state == S_DEL && left == '0) begin
        count <= count - 1'b1;
      end
    end
  end

  // walk and payload registers
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_addr_q <= ptr[AW-1:0];
      rd_last   <= (left == CW'(1));
      left      <= left - 1'b1;
      ptr       <= (state == S_SHIFT_UP) ? ptr - 1'b1 : ptr + 1'b1;
    end
    case (state)
      S_IDLE: begin
        if (accept) begin
          op    <= in_mode;
          val_r <= in_val;
          first <= 1'b1;
          case (in_mode)
            MODE_LIST: begin
              ptr         <= '0;
              left        <= count;
              resp_status <= ST_EMPTY;
              resp_value  <= '0;
            end
            MODE_APPEND: begin
              pos_r       <= count;
              resp_status <= ST_FULL;
              resp_value  <= '0;
            end
            MODE_INSERT: begin
              pos_r       <= CW'(in_pos);
              ptr         <= count - 1'b1;
              left        <= count - CW'(in_pos);
              resp_status <= (pos_ext > cnt_ext) ? ST_IDX_ERR : ST_FULL;
              resp_value  <= '0;
            end
            MODE_DELETE: begin
              ptr         <= CW'(in_pos);
              left        <= count - CW'(in_pos);
              resp_status <= ST_IDX_ERR;
              resp_value  <= '1;  // minus one
            end
            MODE_SUM: begin
              ptr         <= '0;
              left        <= count;
              acc         <= '0;
              resp_status <= ST_OK;
              resp_value  <= '0;
            end
            MODE_MIN: begin
              ptr         <= '0;
              left        <= count;
              acc         <= ACC_W'(MIN_START);
              resp_status <= ST_EMPTY;
              resp_value  <= '0;
            end
            default: begin
              first <= 1'b1;
            end
          endcase
        end
      end
      S_PUT: begin
        // list the grown list from the top
        ptr  <= '0;
        left <= count + 1'b1;
      end
      S_DEL: begin
        if (consume && first) begin
          first       <= 1'b0;
          resp_status <= ST_OK;
          resp_value  <= VAL_W'(rd_data);
        end
      end
      S_SCAN: begin
        if (consume) begin
          if (op == MODE_SUM) begin
            acc <= acc + rd_ext;
          end else if (rd_ext < acc) begin
            acc <= rd_ext;
          end
        end
      end
      S_FIN: begin
        resp_status <= ST_OK;
        resp_value  <= (op == MODE_SUM) ? sum_sat : acc[VAL_W-1:0];
      end
      default: begin
        first <= first;
      end
    endcase
  end

  // checks on the sequencer
  `ILE_ASSERT_NOW(a_count_cap, 1'b1, count <= CW'(CAPACITY), "fill count beyond capacity")
  `ILE_ASSERT_NOW(a_load_free, load.valid, out_free, "result loaded into a busy output stage")
  `ILE_ASSERT_NOW(a_no_collide, mem_we && rd_en, waddr != raddr, "read and write hit one entry")
  `ILE_ASSERT_NOW(a_idle_drained, s_tready, !rd_valid, "idle with a store read in flight")
  `ILE_ASSERT_NEXT(a_put_grows, state == S_PUT, count == $past(count) + 1'b1, "put did not grow list")

endmodule

/* verif/indexed_list_engine_top_test.sv */
// self-checking testbench for the indexed list engine: directed table, then random bursts
module indexed_list_engine_top_test;
  import ile_pkg::*;

  localparam int CAPACITY     = 32;
  localparam int RANDOM_ITEMS = 350;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 48;     // walk of a full list plus margin
  localparam int PRINT_CAP    = 200;    // keep a broken run from flooding the log

  // modes the block ignores, no beats and no state change
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  // one request; typed rows carry their single expected beat
  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [POS_W-1:0]    pos;
    logic [DATA_W-1:0]   val;
    logic                typed;
    logic [STATUS_W-1:0] st;
    logic [VAL_W-1:0]    rv;
  } list_req_t;

  // one expected result beat
  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } list_beat_t;

  // directed table: empty cases, extremes, range errors, spare modes, insert at end
  localparam int DIR_ROWS = 24;
  localparam list_req_t DIRECTED [DIR_ROWS] = '{
    '{MODE_LIST,    6'd0,  16'h0000, 1'b1, ST_EMPTY,   21'd0},       // list of empty list
    '{MODE_MIN,     6'd0,  16'h0000, 1'b1, ST_EMPTY,   21'd0},       // minimum of empty list
    '{MODE_SUM,     6'd0,  16'h0000, 1'b1, ST_OK,      21'd0},       // sum of empty list
    '{MODE_DELETE,  6'd0,  16'h0000, 1'b1, ST_IDX_ERR, 21'h1FFFFF},  // delete on empty list
    '{MODE_INSERT,  6'd1,  16'd5,    1'b1, ST_IDX_ERR, 21'd0},       // insert past end
    '{MODE_INSERT,  6'd0,  16'd20000, 1'b0, ST_OK,     21'd0},       // insert at end of empty
    '{MODE_APPEND,  6'd0,  16'h7FFF, 1'b0, ST_OK,      21'd0},
    '{MODE_MIN,     6'd0,  16'h0000, 1'b1, ST_OK,      21'd10001},   // all above the start
    '{MODE_INSERT,  6'd0,  16'h8000, 1'b0, ST_OK,      21'd0},       // insert at head
    '{MODE_INSERT,  6'd2,  16'h0000, 1'b0, ST_OK,      21'd0},       // insert in middle
    '{MODE_APPEND,  6'd0,  16'hFFFF, 1'b0, ST_OK,      21'd0},
    '{MODE_SUM,     6'd0,  16'h0000, 1'b0, ST_OK,      21'd0},
    '{MODE_MIN,     6'd0,  16'h0000, 1'b1, ST_OK,      21'h1F8000},  // most negative entry
    '{MODE_LIST,    6'd0,  16'h0000, 1'b0, ST_OK,      21'd0},
    '{MODE_DELETE,  6'd63, 16'h0000, 1'b1, ST_IDX_ERR, 21'h1FFFFF},  // top position
    '{MODE_INSERT,  6'd63, 16'h7FFF, 1'b1, ST_IDX_ERR, 21'd0},
    '{MODE_INSERT,  6'd6,  16'h1234, 1'b1, ST_IDX_ERR, 21'd0},       // one past end
    '{MODE_DELETE,  6'd5,  16'h0000, 1'b1, ST_IDX_ERR, 21'h1FFFFF},  // position equals count
    '{MODE_SPARE_6, 6'd63, 16'hFFFF, 1'b0, ST_OK,      21'd0},
    '{MODE_SPARE_7, 6'd42, 16'h5555, 1'b0, ST_OK,      21'd0},
    '{MODE_DELETE,  6'd0,  16'h0000, 1'b1, ST_OK,      21'h1F8000},  // removes head
    '{MODE_DELETE,  6'd3,  16'h0000, 1'b1, ST_OK,      21'h1FFFFF},  // removes tail
    '{MODE_INSERT,  6'd3,  16'd12345, 1'b0, ST_OK,     21'd0},       // insert at end
    '{MODE_LIST,    6'd0,  16'h0000, 1'b0, ST_OK,      21'd0}
  };

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic [STATUS_W-1:0]    m_tuser;
  logic                   m_tlast;

  // shadow copy of the list, updated when a request beat is taken
  logic signed [DATA_W-1:0] list_entries [0:CAPACITY-1];
  int unsigned              list_len;
  list_beat_t               expected_beats [$];

  list_req_t   pending_req;
  bit          req_taken;
  bit          calm_in;
  int          err_count;
  int          cycle_count;
  int unsigned items_sent;
  int unsigned beats_checked;
  int unsigned full_hits;
  int unsigned empty_hits;
  int unsigned range_errs;

  indexed_list_engine_top #(
    .CAPACITY (CAPACITY)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d beats still expected", cycle_count,
             expected_beats.size());
    $display("Regression FAIL");
    $finish;
  end

  task automatic push_beat(input logic [STATUS_W-1:0] st, input logic [VAL_W-1:0] v,
                           input logic lst);
    list_beat_t b;
    b.status = st;
    b.value  = v;
    b.last   = lst;
    expected_beats.push_back(b);
  endtask

  // whole list as a run of beats, or a single empty beat
  task automatic push_listing();
    int unsigned i;
    if (list_len == 0) begin
      push_beat(ST_EMPTY, '0, 1'b1);
      empty_hits++;
    end else begin
      for (i = 0; i < list_len; i++)
        push_beat(ST_OK, VAL_W'(list_entries[i]), (i + 1 == list_len));
    end
  endtask

  // apply one request to the shadow list and queue the beats it causes
  task automatic apply_list_op(input list_req_t rq);
    int          i;
    int          slot;
    int          lowest;
    longint      total;
    int unsigned depth_before;
    depth_before = expected_beats.size();
    case (rq.mode)
      MODE_LIST: push_listing();
      MODE_APPEND, MODE_INSERT: begin
        // position check of insert comes before the full check
        if (rq.mode == MODE_INSERT && 32'(rq.pos) > list_len) begin
          push_beat(ST_IDX_ERR, '0, 1'b1);
          range_errs++;
        end else if (list_len >= CAPACITY) begin
          push_beat(ST_FULL, '0, 1'b1);
          full_hits++;
        end else begin
          slot = (rq.mode == MODE_APPEND) ? int'(list_len) : int'(rq.pos);
          for (i = list_len; i > slot; i--)
            list_entries[i] = list_entries[i-1];
          list_entries[slot] = rq.val;
          list_len++;
          push_listing();
        end
      end
      MODE_DELETE: begin
        if (32'(rq.pos) >= list_len) begin
          push_beat(ST_IDX_ERR, {VAL_W{1'b1}}, 1'b1);
          range_errs++;
        end else begin
          push_beat(ST_OK, VAL_W'(list_entries[rq.pos]), 1'b1);
          for (i = int'(rq.pos); i + 1 < list_len; i++)
            list_entries[i] = list_entries[i+1];
          list_len--;
        end
      end
      MODE_SUM: begin
        total = 0;
        for (i = 0; i < list_len; i++)
          total += longint'(list_entries[i]);
        if (total > 64'sd1048575) total = 64'sd1048575;
        if (total < -64'sd1048576) total = -64'sd1048576;
        push_beat(ST_OK, total[VAL_W-1:0], 1'b1);
      end
      MODE_MIN: begin
        if (list_len == 0) begin
          push_beat(ST_EMPTY, '0, 1'b1);
          empty_hits++;
        end else begin
          lowest = int'(MIN_START);
          for (i = 0; i < list_len; i++)
            if (int'(list_entries[i]) < lowest) lowest = int'(list_entries[i]);
          push_beat(ST_OK, lowest[VAL_W-1:0], 1'b1);
        end
      end
      default: ;  // spare modes are ignored
    endcase
    // typed table rows replace the computed beat with the literal one
    if (rq.typed) begin
      while (expected_beats.size() > depth_before) void'(expected_beats.pop_back());
      push_beat(rq.st, rq.rv, 1'b1);
    end
  endtask

  // one clock of bookkeeping: request handshake first, then result check
  task automatic tick();
    list_beat_t want;
    logic signed [VAL_W-1:0] got_value;
    @(posedge clk);
    if (s_tvalid && s_tready) begin
      req_taken = 1'b1;
      apply_list_op(pending_req);
    end
    if (m_tvalid && m_tready) begin
      beats_checked++;
      got_value = m_tdata[VAL_W-1:0];
      if (expected_beats.size() == 0) begin
        err_count++;
        if (err_count <= PRINT_CAP)
          $display("%0t: beat with nothing expected, got status %0d value %0d last %0b",
                   $time, m_tuser, got_value, m_tlast);
      end else begin
        want = expected_beats.pop_front();
        if (m_tuser !== want.status) begin
          err_count++;
          if (err_count <= PRINT_CAP)
            $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status,
                     m_tuser);
        end
        if (got_value !== want.value) begin
          err_count++;
          if (err_count <= PRINT_CAP)
            $display("%0t: value mismatch, expected %0d, got %0d", $time, want.value,
                     got_value);
        end
        if (m_tlast !== want.last) begin
          err_count++;
          if (err_count <= PRINT_CAP)
            $display("%0t: last mismatch, expected %0b, got %0b", $time, want.last, m_tlast);
        end
      end
    end
  endtask

  // present one request after a random gap and hold it until taken
  task automatic send_req(input list_req_t rq);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) tick();
    end
    s_tdata     <= {7'd0, rq.val, rq.pos, rq.mode};
    s_tvalid    <= 1'b1;
    pending_req  = rq;
    req_taken    = 1'b0;
    while (!req_taken) tick();
    if (rq.mode <= MODE_MIN) items_sent++;
  endtask

  function automatic list_req_t make_req(input logic [MODE_W-1:0] m, input int p,
                                         input logic [DATA_W-1:0] v);
    list_req_t rq;
    rq       = '0;
    rq.mode  = m;
    rq.pos   = p[POS_W-1:0];
    rq.val   = v;
    return rq;
  endfunction

  // values lean toward the extremes
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // result side: random stalls per beat, with calm stretches
  initial begin : result_sink
    int gap;
    int beats;
    bit calm_out;
    m_tready <= 1'b0;
    beats     = 0;
    calm_out  = 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = calm_out ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      beats++;
      if (beats % 50 == 0) calm_out = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin : stimulus
    int          kind;
    int          n;
    int          p;
    bit          extreme;
    logic [DATA_W-1:0] fixed_val;
    logic [MODE_W-1:0] m;
    int unsigned random_base;

    rst           <= 1'b1;
    s_tvalid      <= 1'b0;
    s_tdata       <= '0;
    list_len       = 0;
    err_count      = 0;
    items_sent     = 0;
    beats_checked  = 0;
    full_hits      = 0;
    empty_hits     = 0;
    range_errs     = 0;
    calm_in        = 1'b0;
    req_taken      = 1'b0;
    pending_req    = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part
    for (int r = 0; r < DIR_ROWS; r++)
      send_req(DIRECTED[r]);

    // random part, in bursts that reach a full list and drain it again
    random_base = items_sent;
    while (items_sent < random_base + RANDOM_ITEMS) begin
      calm_in = ($urandom_range(0, 4) == 0);
      kind    = $urandom_range(0, 9);
      if (kind <= 2) begin
        // fill up to capacity, sometimes with one extreme value everywhere
        extreme   = ($urandom_range(0, 3) == 0);
        fixed_val = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        while (list_len < CAPACITY) begin
          if ($urandom_range(0, 1))
            send_req(make_req(MODE_APPEND, $urandom_range(0, 63),
                              extreme ? fixed_val : pick_value()));
          else
            send_req(make_req(MODE_INSERT, $urandom_range(0, list_len),
                              extreme ? fixed_val : pick_value()));
          if ($urandom_range(0, 9) == 0)
            send_req(make_req($urandom_range(0, 1) ? MODE_SUM : MODE_MIN, 0, 0));
        end
        // full list: sum and minimum at its bound, then the full and position errors
        send_req(make_req(MODE_SUM, 0, 0));
        send_req(make_req(MODE_MIN, 0, 0));
        send_req(make_req(MODE_APPEND, $urandom_range(0, 63), pick_value()));
        send_req(make_req(MODE_INSERT, $urandom_range(0, CAPACITY), pick_value()));
        send_req(make_req(MODE_INSERT, $urandom_range(CAPACITY + 1, 63), pick_value()));
      end else if (kind <= 4) begin
        // drain to empty, then poke the empty list
        while (list_len > 0) begin
          send_req(make_req(MODE_DELETE, $urandom_range(0, list_len - 1), DATA_W'($urandom)));
          if ($urandom_range(0, 7) == 0)
            send_req(make_req($urandom_range(0, 1) ? MODE_SUM : MODE_MIN, 0, 0));
        end
        send_req(make_req(MODE_DELETE, $urandom_range(0, 63), 0));
        send_req(make_req(MODE_LIST, 0, 0));
        send_req(make_req(MODE_MIN, 0, 0));
        send_req(make_req(MODE_SUM, 0, 0));
      end else if (kind <= 8) begin
        // well-formed mix with an occasional stray position
        n = $urandom_range(6, 20);
        repeat (n) begin
          m = MODE_W'($urandom_range(0, 5));
          if (m == MODE_INSERT) p = $urandom_range(0, list_len);
          else if (m == MODE_DELETE && list_len > 0) p = $urandom_range(0, list_len - 1);
          else p = $urandom_range(0, 63);
          if ($urandom_range(0, 7) == 0) p = $urandom_range(0, 63);
          send_req(make_req(m, p, pick_value()));
        end
      end else begin
        // noise: any mode, spare ones too, any position
        n = $urandom_range(3, 8);
        repeat (n)
          send_req(make_req(MODE_W'($urandom_range(0, 7)), $urandom_range(0, 63),
                            DATA_W'($urandom)));
      end
    end

    // wind down: no more requests, wait for every expected beat
    s_tvalid <= 1'b0;
    while (expected_beats.size() != 0) tick();
    repeat (DRAIN_CYCLES) tick();

    $display("%0d requests, %0d result beats checked in %0d cycles", items_sent,
             beats_checked, cycle_count);
    $display("%0d full-list refusals, %0d empty-list reports, %0d position errors",
             full_hits, empty_hits, range_errs);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", err_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
